/* src/ouart_pkg.sv */
// ----------------------------------------------------------------------------
// ouart_pkg
// Shared constants, state encoding and result item type for the oversampled
// serial receiver.
// ----------------------------------------------------------------------------
package ouart_pkg;

    // frame format and oversampling
    localparam int DATA_BITS       = 8;
    localparam int SAMPLES_PER_BIT = 3;

    // derived widths
    localparam int BITS_CNT_W = $clog2(DATA_BITS + 1);
    localparam int WAIT_CNT_W = (SAMPLES_PER_BIT > 2) ? $clog2(SAMPLES_PER_BIT - 1) : 1;
    localparam int BYTE_W     = 8;
    localparam int BACKOFF_W  = 8;

    // last wait count before the sampling tick
    localparam logic [WAIT_CNT_W-1:0] WAIT_LAST = WAIT_CNT_W'(SAMPLES_PER_BIT - 2);

    // backoff length after reset
    localparam logic [BACKOFF_W-1:0] BACKOFF_RESET = BACKOFF_W'(60);

    // stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // receiver phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_WAIT,
        PH_SAMPLE
    } phase_t;

    // one result item
    typedef struct packed {
        logic [BACKOFF_W-1:0] backoff_left;
        logic                 receiving;
        logic                 framing_error;
        logic [BYTE_W-1:0]    rx_byte;
        logic                 byte_valid;
    } out_item_t;

endpackage

/* src/oversampled_uart_receiver_unit.sv */
// ----------------------------------------------------------------------------
// oversampled_uart_receiver_unit
// Serial receiver fed with one line sample per transaction, three samples per
// bit, with frame checking, busy flag and carrier-detect backoff counter.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one line sample per transaction (tdata bit 0, 1 = mark).
//   Every accepted sample produces exactly one m_axis transaction holding
//   the receiver status after that sample: tuser flags a completed byte with
//   a good stop bit, tdata carries the byte, framing error, busy flag and
//   the backoff count.
//   The result of an accepted sample is registered in the output stage, or in
//   the skid stage while m_axis stalls. Throughput is one sample per cycle
//   while the skid register is empty; the state update is a single pass of
//   logic between the sample and the result register. When m_axis stalls,
//   one more sample is still taken into a skid register; s_axis_tready drops
//   only while the skid register is full. The backoff length is written
//   through cfg_we/cfg_wdata; the user is to write it only while the stream
//   is idle, the block does not enforce it. It is used at the next start or
//   stop bit. Reset puts the receiver in idle, clears all flags, the backoff
//   count and both output stages, and sets the backoff length to 60 samples.
// ----------------------------------------------------------------------------
module oversampled_uart_receiver_unit (
    input  logic                               clk,
    input  logic                               rst_n,

    // configuration
    input  logic                               cfg_we,
    input  logic [ouart_pkg::BACKOFF_W-1:0]    cfg_wdata,

    // line samples
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ouart_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [0] line_is_mark, [7:1] zero

    // receiver status
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ouart_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [7:0] rx_byte,
                                                              // [8] framing_error,
                                                              // [9] receiving,
                                                              // [17:10] backoff_left,
                                                              // [23:18] zero
    output logic                               m_axis_tuser   // [0] byte_valid
);

    // receiver state
    ouart_pkg::phase_t                      phase_reg,   phase_next;
    logic [ouart_pkg::WAIT_CNT_W-1:0]       wait_reg,    wait_next;
    logic [ouart_pkg::DATA_BITS-1:0]        shift_reg,   shift_next;
    logic [ouart_pkg::BITS_CNT_W-1:0]       bits_reg,    bits_next;
    logic [ouart_pkg::BACKOFF_W-1:0]        backoff_reg, backoff_next;
    logic                                   error_reg,   error_next;
    logic                                   busy_reg,    busy_next;
    logic [ouart_pkg::BACKOFF_W-1:0]        reload_reg;

    // output and skid stages
    ouart_pkg::out_item_t                   out_reg,  skid_reg;
    logic                                   out_valid_reg, skid_valid_reg;

    ouart_pkg::out_item_t                   item_new;
    logic                                   mark;
    logic                                   in_take;
    logic                                   out_take;

    assign mark     = s_axis_tdata[0];
    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.byte_valid;
    assign m_axis_tdata  = {{(ouart_pkg::OUT_TDATA_W - 18){1'b0}},
                            out_reg.backoff_left,
                            out_reg.receiving,
                            out_reg.framing_error,
                            out_reg.rx_byte};

    // backoff length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= ouart_pkg::BACKOFF_RESET;
        end
        else if (cfg_we)
        begin
            reload_reg <= cfg_wdata;
        end
    end

    // next state and result for one sample
    always_comb
    begin
        phase_next   = phase_reg;
        wait_next    = wait_reg;
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        backoff_next = backoff_reg;
        error_next   = error_reg;
        busy_next    = busy_reg;
        item_new.byte_valid = 1'b0;
        item_new.rx_byte    = '0;

        case (phase_reg)
            ouart_pkg::PH_IDLE:
            begin
                if (!mark)
                begin
                    phase_next   = ouart_pkg::PH_START;
                    shift_next   = '0;
                    bits_next    = '0;
                    backoff_next = reload_reg;
                    busy_next    = 1'b1;
                end
                else
                begin
                    if (backoff_reg != '0)
                    begin
                        backoff_next = backoff_reg - 1'b1;
                    end
                    busy_next = 1'b0;
                end
            end
            ouart_pkg::PH_START:
            begin
                // a mark here means the start was a glitch
                if (mark)
                begin
                    phase_next = ouart_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = ouart_pkg::PH_WAIT;
                    wait_next  = '0;
                end
            end
            ouart_pkg::PH_WAIT:
            begin
                if (wait_reg == ouart_pkg::WAIT_LAST)
                begin
                    phase_next = ouart_pkg::PH_SAMPLE;
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            ouart_pkg::PH_SAMPLE:
            begin
                if (bits_reg < ouart_pkg::BITS_CNT_W'(ouart_pkg::DATA_BITS))
                begin
                    // data bit enters at the top, lsb first on the line
                    shift_next = {mark, shift_reg[ouart_pkg::DATA_BITS-1:1]};
                    bits_next  = bits_reg + 1'b1;
                    phase_next = ouart_pkg::PH_WAIT;
                    wait_next  = '0;
                end
                else
                begin
                    // stop bit check
                    if (mark)
                    begin
                        item_new.byte_valid = 1'b1;
                        item_new.rx_byte    = ouart_pkg::BYTE_W'(shift_reg);
                        error_next          = 1'b0;
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                    phase_next   = ouart_pkg::PH_IDLE;
                    backoff_next = reload_reg;
                end
            end
            default:
            begin
                phase_next = ouart_pkg::PH_IDLE;
            end
        endcase

        item_new.framing_error = error_next;
        item_new.receiving     = busy_next;
        item_new.backoff_left  = backoff_next;
    end

    // receiver state update on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ouart_pkg::PH_IDLE;
            wait_reg    <= '0;
            shift_reg   <= '0;
            bits_reg    <= '0;
            backoff_reg <= '0;
            error_reg   <= 1'b0;
            busy_reg    <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg   <= phase_next;
            wait_reg    <= wait_next;
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            backoff_reg <= backoff_next;
            error_reg   <= error_next;
            busy_reg    <= busy_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload of the output and skid stages
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= item_new;
            end
            else
            begin
                out_reg <= item_new;
            end
        end
    end

endmodule
